// ----- src/bdpc_pkg.sv -----
// Package for the button debouncer and press classifier: widths, codes and reset values.
package bdpc_pkg;

    localparam int unsigned TimeWidth   = 32;
    localparam int unsigned ThreshWidth = 16;
    localparam int unsigned EventWidth  = 2;
    localparam int unsigned CfgIdxWidth = 2;

    // s_tdata: pin_level, now_time, zero pad to whole bytes
    localparam int unsigned SDataWidth  = 40;
    // m_tdata: press_event, is_pressed, zero pad to whole bytes
    localparam int unsigned MDataWidth  = 8;

    typedef enum logic [EventWidth-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_event_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_ACTIVE_LEVEL    = 2'd0,
        CFG_DEBOUNCE_TIME   = 2'd1,
        CFG_LONG_PRESS_TIME = 2'd2
    } cfg_index_t;

    localparam logic                   ActiveLevelReset   = 1'b0;
    localparam logic [ThreshWidth-1:0] DebounceTimeReset  = 16'd30;
    localparam logic [ThreshWidth-1:0] LongPressTimeReset = 16'd2000;

endpackage

// ----- src/button_debounce_press_classifier.sv -----
// Button debouncer with short and long press classification, top level.
//
//  channel  dir  handshake              word layout (lsb first)
//  s_       in   s_tvalid / s_tready    pin_level[0], now_time[32:1], zero[39:33]
//  m_       out  m_tvalid / m_tready    press_event[1:0], is_pressed[2], zero[7:3]
//  cfg_     in   cfg_we                 cfg_index selects register, cfg_wdata value
//
// One word per cycle while s_tready is high: each accepted sample is classified in the
// cycle it is taken and its result appears in the output register on the next edge.
// The 32-bit timestamp subtract and compare against the threshold set the path.
// s_tready drops only while the output register is full and m_tready is low.
// aresetn is synchronous and active low; reset gives released state, zero
// timestamps and the default thresholds.
module button_debounce_press_classifier (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pin_level, now_time
    input  logic [bdpc_pkg::SDataWidth-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // press_event, is_pressed
    output logic [bdpc_pkg::MDataWidth-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [bdpc_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [bdpc_pkg::ThreshWidth-1:0]  cfg_wdata
);
    import bdpc_pkg::*;

    logic                   active_level_reg;
    logic [ThreshWidth-1:0] debounce_time_reg;
    logic [ThreshWidth-1:0] long_press_time_reg;

    logic                   last_raw_reg,     last_raw_next;
    logic [TimeWidth-1:0]   change_time_reg,  change_time_next;
    logic                   held_reg,         held_next;
    logic [TimeWidth-1:0]   press_start_reg,  press_start_next;
    logic                   long_seen_reg,    long_seen_next;

    logic                   out_valid_reg;
    press_event_t           out_event_reg,    out_event_next;
    logic                   out_pressed_reg;

    logic                   pin_level;
    logic [TimeWidth-1:0]   now_time;
    logic                   raw;
    logic [TimeWidth-1:0]   stable_span;
    logic [TimeWidth-1:0]   press_span;
    logic                   accept;

    assign pin_level = s_tdata[0];
    assign now_time  = s_tdata[TimeWidth:1];
    assign raw       = (pin_level == active_level_reg);

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(MDataWidth-EventWidth-1){1'b0}}, out_pressed_reg, out_event_reg};

    // held doubles as the debounced level: both move together
    always_comb begin
        last_raw_next    = raw;
        change_time_next = (raw != last_raw_reg) ? now_time : change_time_reg;
        held_next        = held_reg;
        press_start_next = press_start_reg;
        long_seen_next   = long_seen_reg;
        out_event_next   = EV_NONE;

        stable_span = now_time - change_time_next;
        if (stable_span >= {{(TimeWidth-ThreshWidth){1'b0}}, debounce_time_reg}
                && held_reg != raw) begin
            held_next = raw;
            if (raw) begin
                press_start_next = now_time;
                long_seen_next   = 1'b0;
            end else if (!long_seen_reg) begin
                out_event_next = EV_SHORT;
            end
        end

        press_span = now_time - press_start_next;
        if (held_next && !long_seen_next
                && press_span >= {{(TimeWidth-ThreshWidth){1'b0}}, long_press_time_reg}) begin
            long_seen_next = 1'b1;
            out_event_next = EV_LONG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg    <= ActiveLevelReset;
            debounce_time_reg   <= DebounceTimeReset;
            long_press_time_reg <= LongPressTimeReset;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACTIVE_LEVEL:    active_level_reg    <= cfg_wdata[0];
                CFG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_wdata;
                CFG_LONG_PRESS_TIME: long_press_time_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg    <= 1'b0;
            change_time_reg <= '0;
            held_reg        <= 1'b0;
            press_start_reg <= '0;
            long_seen_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                last_raw_reg    <= last_raw_next;
                change_time_reg <= change_time_next;
                held_reg        <= held_next;
                press_start_reg <= press_start_next;
                long_seen_reg   <= long_seen_next;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_event_reg   <= out_event_next;
            out_pressed_reg <= held_next;
        end
    end

endmodule
